/* src/assert_macros.svh */
// Assertion macros used by the checker file of this project.
// Plain text only; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under a synchronous active-low reset
`define TTW_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication under a synchronous active-low reset
`define TTW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* src/ttw_pkg.sv */
// Package for the text terminal writer: default sizes, reset values, command codes, register indexes,
// character constants and the sequencer state type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ttw_pkg;

  localparam int DEF_MAX_COLS = 128;
  localparam int DEF_MAX_ROWS = 32;

  localparam logic [7:0] MARK_CHAR    = 8'h5F;
  localparam logic [7:0] SPACE_CHAR   = 8'h20;
  localparam logic [7:0] NEWLINE_CHAR = 8'h0A;

  localparam logic [7:0] RESET_COLOR = 8'h07;
  localparam logic [7:0] RESET_COLS  = 8'd80;
  localparam logic [5:0] RESET_ROWS  = 6'd25;

  // command codes
  localparam logic [2:0] CMD_PUT   = 3'd0;
  localparam logic [2:0] CMD_SET   = 3'd1;
  localparam logic [2:0] CMD_CLEAR = 3'd2;
  localparam logic [2:0] CMD_SHOW  = 3'd3;
  localparam logic [2:0] CMD_HIDE  = 3'd4;
  localparam logic [2:0] CMD_READ  = 3'd5;

  // configuration register indexes
  localparam logic [1:0] REG_COLOR = 2'd0;
  localparam logic [1:0] REG_COLS  = 2'd1;
  localparam logic [1:0] REG_ROWS  = 2'd2;

  typedef enum logic [3:0] {
    S_FILL,
    S_IDLE,
    S_UNMARK_RD,
    S_UNMARK_WR,
    S_DISPATCH,
    S_PUT_WR,
    S_NEXT_ROW,
    S_COPY,
    S_SFILL,
    S_CLEAR,
    S_MARK_CHECK,
    S_MARK,
    S_MARK_WR,
    S_RD_ISSUE,
    S_RD_WAIT,
    S_DONE
  } ttw_state_t;

endpackage

`default_nettype wire

/* src/text_terminal_writer.sv */
// Text terminal writer: one sequencer around one cell memory and one
// shared index multiply-add unit. Depends on ttw_pkg.
//
// - in_valid/in_stall: one command transaction (cmd, char_code, col_arg,
//   row_arg). in_stall is high while a command runs or a result waits.
// - out_valid/out_stall: one result transaction per command: cursor
//   position, cursor flag and, for a cell read, the cell word.
// - cfg_we/cfg_index/cfg_data write text_color, columns or rows. Writing
//   columns or rows refills the whole memory with spaces and homes and
//   hides the cursor.
// - A mark placement sweeps the active area A = rows*columns one cell per
//   cycle, a scroll copies it up one row and refills the last row, and a
//   clear writes it once. Only one command runs at a time.
// - Reset: a clearing pass over the whole memory writes spaces with
//   attribute 7; no command is taken during it.
// - A stalled result holds; the next command waits until it is taken.
`timescale 1ns / 1ps
`default_nettype none

module text_terminal_writer
  import ttw_pkg::*;
#(
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int MAX_ROWS = DEF_MAX_ROWS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_cmd,
  input  wire logic [7:0]  in_char_code,
  input  wire logic [6:0]  in_col_arg,
  input  wire logic [4:0]  in_row_arg,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [4:0]       out_cursor_row_out,
  output logic [6:0]       out_cursor_col_out,
  output logic             out_cursor_shown,
  output logic [15:0]      out_cell_word,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  localparam int CELLS = MAX_COLS * MAX_ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CNTW  = $clog2(CELLS + 1);
  localparam int CCW   = $clog2(MAX_COLS);
  localparam int RCW   = $clog2(MAX_ROWS);

  // cell memory
  logic [15:0] mem [CELLS];
  logic [15:0] mem_rd_r;
  logic        mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [15:0] mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rd_r <= mem[mem_raddr];
  end

  // registers
  ttw_state_t state_r, state_nxt;
  logic [7:0]  color_r, color_nxt;
  logic [7:0]  cols_r, cols_nxt;
  logic [5:0]  rows_r, rows_nxt;
  logic [7:0]  fill_attr_r, fill_attr_nxt;
  logic [CCW-1:0] cur_col_r, cur_col_nxt;
  logic [RCW-1:0] cur_row_r, cur_row_nxt;
  logic        cur_on_r, cur_on_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [CNTW-1:0] area_r, area_nxt;
  logic        sv_valid_r, sv_valid_nxt;
  logic [AW-1:0] sv_idx_r, sv_idx_nxt;
  logic [7:0]  mark_attr_r, mark_attr_nxt;
  logic [2:0]  cmd_r, cmd_nxt;
  logic [7:0]  ch_r, ch_nxt;
  logic [6:0]  ca_r, ca_nxt;
  logic [4:0]  ra_r, ra_nxt;
  logic [15:0] word_r, word_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [4:0]  out_row_r, out_row_nxt;
  logic [6:0]  out_col_r, out_col_nxt;
  logic        out_on_r, out_on_nxt;
  logic [15:0] out_word_r, out_word_nxt;

  // active geometry, clamped
  logic [15:0] w16, h16;
  always_comb begin
    if (cols_r == 8'd0) w16 = 16'd1;
    else if (16'(cols_r) > 16'(MAX_COLS)) w16 = 16'(MAX_COLS);
    else w16 = 16'(cols_r);
    if (rows_r == 6'd0) h16 = 16'd1;
    else if (16'(rows_r) > 16'(MAX_ROWS)) h16 = 16'(MAX_ROWS);
    else h16 = 16'(rows_r);
  end

  // shared index unit: row * width + column (rows * width while idle)
  logic [15:0] mac_row, mac_add;
  logic [CNTW-1:0] mac;
  logic [31:0] mac_full;
  always_comb begin
    if (state_r == S_IDLE) begin
      mac_row = h16;
      mac_add = 16'd0;
    end else if (state_r == S_RD_ISSUE) begin
      mac_row = 16'(ra_r);
      mac_add = 16'(ca_r);
    end else begin
      mac_row = 16'(cur_row_r);
      mac_add = 16'(cur_col_r);
    end
    mac_full = mac_row * w16 + 32'(mac_add);
    mac = mac_full[CNTW-1:0];
  end

  logic accept;
  logic in_range;
  logic sweep_issue;
  logic [CNTW-1:0] sweep_lim;
  logic [CNTW-1:0] w_cnt;

  assign accept   = in_valid && !in_stall;
  assign w_cnt    = CNTW'(w16);
  assign in_range = (16'(ca_r) < w16) && (16'(ra_r) < h16);
  assign sweep_lim = (state_r == S_COPY) ? (area_r - w_cnt) : area_r;
  assign sweep_issue = cnt_r < sweep_lim;

  // next state and register updates
  always_comb begin
    state_nxt     = state_r;
    color_nxt     = color_r;
    cols_nxt      = cols_r;
    rows_nxt      = rows_r;
    fill_attr_nxt = fill_attr_r;
    cur_col_nxt   = cur_col_r;
    cur_row_nxt   = cur_row_r;
    cur_on_nxt    = cur_on_r;
    cnt_nxt       = cnt_r;
    area_nxt      = area_r;
    sv_valid_nxt  = 1'b0;
    sv_idx_nxt    = cnt_r[AW-1:0];
    mark_attr_nxt = mark_attr_r;
    cmd_nxt       = cmd_r;
    ch_nxt        = ch_r;
    ca_nxt        = ca_r;
    ra_nxt        = ra_r;
    word_nxt      = word_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    out_on_nxt    = out_on_r;
    out_word_nxt  = out_word_r;

    unique case (state_r)
      S_FILL: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNTW'(CELLS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        area_nxt = mac;
        if (accept) begin
          cmd_nxt  = in_cmd;
          ch_nxt   = in_char_code;
          ca_nxt   = in_col_arg;
          ra_nxt   = in_row_arg;
          word_nxt = 16'd0;
          unique case (in_cmd) inside
            CMD_PUT, CMD_SET, CMD_CLEAR:
              state_nxt = cur_on_r ? S_UNMARK_RD : S_DISPATCH;
            CMD_SHOW: begin
              cur_on_nxt = 1'b1;
              cnt_nxt    = '0;
              state_nxt  = S_MARK;
            end
            CMD_HIDE: begin
              cur_on_nxt = 1'b0;
              state_nxt  = S_UNMARK_RD;
            end
            CMD_READ: state_nxt = S_RD_ISSUE;
            default:  state_nxt = S_DONE;
          endcase
        end
      end
      S_UNMARK_RD: state_nxt = S_UNMARK_WR;
      S_UNMARK_WR: state_nxt = S_DISPATCH;
      S_DISPATCH: begin
        unique case (cmd_r)
          CMD_PUT: state_nxt = (ch_r == NEWLINE_CHAR) ? S_NEXT_ROW : S_PUT_WR;
          CMD_SET: begin
            if (in_range) begin
              cur_col_nxt = CCW'(ca_r);
              cur_row_nxt = RCW'(ra_r);
            end
            state_nxt = S_MARK_CHECK;
          end
          CMD_CLEAR: begin
            cnt_nxt   = '0;
            state_nxt = S_CLEAR;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_PUT_WR: begin
        if (16'(cur_col_r) + 16'd1 >= w16) begin
          state_nxt = S_NEXT_ROW;
        end else begin
          cur_col_nxt = cur_col_r + 1'b1;
          state_nxt   = S_MARK_CHECK;
        end
      end
      S_NEXT_ROW: begin
        cur_col_nxt = '0;
        if (16'(cur_row_r) + 16'd1 >= h16) begin
          cnt_nxt   = '0;
          state_nxt = S_COPY;
        end else begin
          cur_row_nxt = cur_row_r + 1'b1;
          state_nxt   = S_MARK_CHECK;
        end
      end
      S_COPY: begin
        sv_valid_nxt = sweep_issue;
        if (sweep_issue) cnt_nxt = cnt_r + 1'b1;
        else if (!sv_valid_r) state_nxt = S_SFILL;
      end
      S_SFILL: begin
        if (cnt_r < area_r) cnt_nxt = cnt_r + 1'b1;
        else state_nxt = S_MARK_CHECK;
      end
      S_CLEAR: begin
        if (cnt_r < area_r) begin
          cnt_nxt = cnt_r + 1'b1;
        end else begin
          cur_col_nxt = '0;
          cur_row_nxt = '0;
          state_nxt   = S_MARK_CHECK;
        end
      end
      S_MARK_CHECK: begin
        cnt_nxt   = '0;
        state_nxt = cur_on_r ? S_MARK : S_DONE;
      end
      S_MARK: begin
        sv_valid_nxt = sweep_issue;
        if (sv_valid_r && (CNTW'(sv_idx_r) == mac)) mark_attr_nxt = mem_rd_r[15:8];
        if (sweep_issue) cnt_nxt = cnt_r + 1'b1;
        else if (!sv_valid_r) state_nxt = S_MARK_WR;
      end
      S_MARK_WR: state_nxt = S_DONE;
      S_RD_ISSUE: state_nxt = in_range ? S_RD_WAIT : S_DONE;
      S_RD_WAIT: begin
        word_nxt  = mem_rd_r;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        out_valid_nxt = 1'b1;
        out_row_nxt   = 5'(cur_row_r);
        out_col_nxt   = 7'(cur_col_r);
        out_on_nxt    = cur_on_r;
        out_word_nxt  = word_r;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase

    // the user must write configuration only while idle or filling; the block does not enforce it
    if (cfg_we) begin
      unique case (cfg_index) inside
        REG_COLOR: color_nxt = cfg_data;
        REG_COLS, REG_ROWS: begin
          if (cfg_index == REG_COLS) cols_nxt = cfg_data;
          else rows_nxt = cfg_data[5:0];
          fill_attr_nxt = color_r;
          cnt_nxt       = '0;
          cur_col_nxt   = '0;
          cur_row_nxt   = '0;
          cur_on_nxt    = 1'b0;
          state_nxt     = S_FILL;
        end
        default: ;
      endcase
    end
  end

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = mac[AW-1:0];
    mem_wdata = {color_r, SPACE_CHAR};
    mem_raddr = mac[AW-1:0];
    unique case (state_r)
      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r[AW-1:0];
        mem_wdata = {fill_attr_r, SPACE_CHAR};
      end
      S_UNMARK_WR: begin
        mem_we    = (mem_rd_r[7:0] == MARK_CHAR);
        mem_wdata = {mem_rd_r[15:8], SPACE_CHAR};
      end
      S_PUT_WR: begin
        mem_we    = 1'b1;
        mem_wdata = {color_r, ch_r};
      end
      S_COPY: begin
        mem_raddr = AW'(cnt_r + w_cnt);
        mem_we    = sv_valid_r;
        mem_waddr = sv_idx_r;
        mem_wdata = mem_rd_r;
      end
      S_SFILL, S_CLEAR: begin
        mem_we    = cnt_r < area_r;
        mem_waddr = cnt_r[AW-1:0];
      end
      S_MARK: begin
        mem_raddr = cnt_r[AW-1:0];
        mem_we    = sv_valid_r && (mem_rd_r[7:0] == MARK_CHAR)
                    && (CNTW'(sv_idx_r) != mac);
        mem_waddr = sv_idx_r;
        mem_wdata = {mem_rd_r[15:8], SPACE_CHAR};
      end
      S_MARK_WR: begin
        mem_we    = 1'b1;
        mem_wdata = {mark_attr_r, MARK_CHAR};
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_FILL;
      color_r     <= RESET_COLOR;
      cols_r      <= RESET_COLS;
      rows_r      <= RESET_ROWS;
      fill_attr_r <= RESET_COLOR;
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      cur_on_r    <= 1'b0;
      cnt_r       <= '0;
      sv_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      color_r     <= color_nxt;
      cols_r      <= cols_nxt;
      rows_r      <= rows_nxt;
      fill_attr_r <= fill_attr_nxt;
      cur_col_r   <= cur_col_nxt;
      cur_row_r   <= cur_row_nxt;
      cur_on_r    <= cur_on_nxt;
      cnt_r       <= cnt_nxt;
      sv_valid_r  <= sv_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    area_r      <= area_nxt;
    sv_idx_r    <= sv_idx_nxt;
    mark_attr_r <= mark_attr_nxt;
    cmd_r       <= cmd_nxt;
    ch_r        <= ch_nxt;
    ca_r        <= ca_nxt;
    ra_r        <= ra_nxt;
    word_r      <= word_nxt;
    out_row_r   <= out_row_nxt;
    out_col_r   <= out_col_nxt;
    out_on_r    <= out_on_nxt;
    out_word_r  <= out_word_nxt;
  end

  assign in_stall           = (state_r != S_IDLE) || out_valid_r;
  assign out_valid          = out_valid_r;
  assign out_cursor_row_out = out_row_r;
  assign out_cursor_col_out = out_col_r;
  assign out_cursor_shown   = out_on_r;
  assign out_cell_word      = out_word_r;

endmodule

`default_nettype wire

/* src/ttw_checker.sv */
// Port-level checker for text_terminal_writer, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ttw_port_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [15:0] out_cell_word
);

  // a stalled result holds
  `TTW_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_cell_word))
  // a taken command blocks the input while it runs
  `TTW_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
  // one result per command: no result right after one is taken
  `TTW_ASSERT_NEXT(a_no_back_to_back, clk, rst_n, out_valid && !out_stall, !out_valid)
  // a pending result keeps the input stalled
  `TTW_ASSERT_IMPL(a_result_blocks, clk, rst_n, out_valid, in_stall)

endmodule

bind text_terminal_writer ttw_port_checker u_ttw_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_cell_word (out_cell_word)
);

`default_nettype wire
